// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("implication check failed");
`define ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, pre, post)
`define ASSERT_NEXT(label, pre, post)
`endif
`endif

// File: hdl/rau_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Opcodes, status codes, sequencer states and operand decode helpers.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int MAG_W         = OPERAND_WIDTH;
  localparam int WIDE_W        = 64;

  localparam logic [2:0] CMD_NORM = 3'd0;
  localparam logic [2:0] CMD_ADD  = 3'd1;
  localparam logic [2:0] CMD_SUB  = 3'd2;
  localparam logic [2:0] CMD_MUL  = 3'd3;
  localparam logic [2:0] CMD_DIV  = 3'd4;
  localparam logic [2:0] CMD_INV  = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_MUL1  = 4'd2;
  localparam logic [3:0] S_MUL2  = 4'd3;
  localparam logic [3:0] S_MUL3  = 4'd4;
  localparam logic [3:0] S_COMB  = 4'd5;
  localparam logic [3:0] S_GTWO  = 4'd6;
  localparam logic [3:0] S_GODD  = 4'd7;
  localparam logic [3:0] S_GLOOP = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  typedef logic [MAG_W-1:0] mag_t;

  // Sign of an operand field, taken from its low OPERAND_WIDTH bits.
  function automatic logic op_sign(input logic [31:0] raw);
    op_sign = raw[OPERAND_WIDTH-1];
  endfunction

  // Magnitude of an operand field, taken from its low OPERAND_WIDTH bits.
  function automatic mag_t op_mag(input logic [31:0] raw);
    mag_t v;
    v = raw[OPERAND_WIDTH-1:0];
    op_mag = v[MAG_W-1] ? (~v + mag_t'(1)) : v;
  endfunction

endpackage

// File: hdl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Exact fraction arithmetic with result reduction by a binary GCD.
// ----------------------------------------------------------------------------
// A zero denominator or a division by zero goes from the operand check
// straight to the result. Otherwise normalize and invert go from the check to
// the combine step, while add, subtract, multiply and divide first pass through
// the multiplier steps; then follow the GCD shifts and subtracts on 64-bit
// values and a restoring division; a zero numerator skips the GCD and the division.
// Throughput: one item at a time; the input is ready only while idle.
// Reset: synchronous active-high rst clears the sequencer and output valid.
module rational_arithmetic_unit
  import rau_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
  input  logic [2:0]   s_tuser,  // cmd[2:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,  // res_num[63:0], res_den[126:64], zero pad[127]
  output logic [1:0]   m_tuser   // status[1:0]
);

  `include "assert_macros.svh"

  logic [3:0]        state;
  logic [2:0]        cmd;
  logic [31:0]       a_num, a_den, b_num, b_den;
  logic [1:0]        st;
  logic              neg;
  logic              ovf;
  logic [WIDE_W-1:0] prod, p1, p2;
  logic [WIDE_W-1:0] nm, dn;
  logic [WIDE_W-1:0] gx, gy;
  logic [6:0]        k;
  logic [5:0]        cnt;
  logic [WIDE_W-1:0] qn, qd, rn, rd;

  // Decoded operands: magnitude of each field, sign of each fraction from its two fields.
  mag_t ma_n, ma_d, mb_n, mb_d;
  logic a_neg, b_neg, binary;
  assign ma_n   = op_mag(a_num);
  assign ma_d   = op_mag(a_den);
  assign mb_n   = op_mag(b_num);
  assign mb_d   = op_mag(b_den);
  assign a_neg  = op_sign(a_num) ^ op_sign(a_den);
  assign b_neg  = op_sign(b_num) ^ op_sign(b_den);
  assign binary = (cmd == CMD_ADD) || (cmd == CMD_SUB) || (cmd == CMD_MUL) ||
                  (cmd == CMD_DIV);

  // The one shared multiplier; its operands follow the sequencer step.
  mag_t mul_x, mul_y;
  always_comb begin
    mul_x = ma_n;
    mul_y = mb_d;
    case (state)
      S_MUL1: begin
        mul_x = ma_n;
        mul_y = (cmd == CMD_MUL) ? mb_n : mb_d;
      end
      S_MUL2: begin
        mul_x = mb_n;
        mul_y = ma_d;
      end
      S_MUL3: begin
        mul_x = ma_d;
        mul_y = (cmd == CMD_DIV) ? mb_n : mb_d;
      end
      default: begin
        mul_x = ma_n;
        mul_y = mb_d;
      end
    endcase
  end

  logic [WIDE_W-1:0] mul_p;
  assign mul_p = WIDE_W'(mul_x) * WIDE_W'(mul_y);

  // Signed combination of the cross products for add and subtract.
  logic              s2;
  logic [WIDE_W:0]   sum;
  assign s2  = (cmd == CMD_SUB) ? ~b_neg : b_neg;
  assign sum = {1'b0, p1} + {1'b0, p2};

  // One step of the paired restoring divisions by the gcd.
  logic [WIDE_W:0] tn, td;
  logic            gen, ged;
  assign tn  = {rn, qn[WIDE_W-1]};
  assign td  = {rd, qd[WIDE_W-1]};
  assign gen = tn >= {1'b0, gx};
  assign ged = td >= {1'b0, gx};

  // Final range check on the reduced result.
  logic res_ovf;
  assign res_ovf = qd[WIDE_W-1] || (neg ? (qn > {1'b1, {(WIDE_W-1){1'b0}}}) : qn[WIDE_W-1]);

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd   <= s_tuser;
            a_num <= s_tdata[31:0];
            a_den <= s_tdata[63:32];
            b_num <= s_tdata[95:64];
            b_den <= s_tdata[127:96];
            ovf   <= 1'b0;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          // Status priority: zero denominator, then division by zero.
          if (ma_d == '0 || (binary && mb_d == '0)) begin
            st    <= ST_ZERO_DEN;
            state <= S_DONE;
          end else if ((cmd == CMD_DIV && mb_n == '0) ||
                       (cmd == CMD_INV && ma_n == '0)) begin
            st    <= ST_DIV_ZERO;
            state <= S_DONE;
          end else begin
            st <= ST_OK;
            if (cmd == CMD_INV) begin
              nm    <= WIDE_W'(ma_d);
              dn    <= WIDE_W'(ma_n);
              neg   <= a_neg;
              state <= S_COMB;
            end else if (!binary) begin
              nm    <= WIDE_W'(ma_n);
              dn    <= WIDE_W'(ma_d);
              neg   <= a_neg;
              state <= S_COMB;
            end else begin
              state <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          prod  <= mul_p;
          state <= S_MUL2;
        end
        S_MUL2: begin
          p1    <= prod;
          prod  <= mul_p;
          state <= S_MUL3;
        end
        S_MUL3: begin
          p2    <= prod;
          prod  <= mul_p;
          dn    <= mul_p;
          state <= S_COMB;
          if (cmd == CMD_ADD || cmd == CMD_SUB) begin
            // Sum is formed next cycle from p1 and p2.
          end else begin
            nm  <= p1;
            neg <= a_neg ^ b_neg;
          end
        end
        S_COMB: begin
          if ((cmd == CMD_ADD || cmd == CMD_SUB) && binary) begin
            if (a_neg == s2) begin
              nm  <= sum[WIDE_W-1:0];
              ovf <= sum[WIDE_W];
              neg <= a_neg;
            end else if (p1 >= p2) begin
              nm  <= p1 - p2;
              neg <= a_neg;
            end else begin
              nm  <= p2 - p1;
              neg <= s2;
            end
          end
          gx    <= '0;
          state <= S_GTWO;
        end
        S_GTWO: begin
          // First visit loads the GCD registers; a zero numerator skips it.
          if (gx == '0) begin
            if (nm == '0) begin
              qn    <= '0;
              qd    <= WIDE_W'(1);
              neg   <= 1'b0;
              state <= S_DONE;
            end else begin
              gx <= nm;
              gy <= dn;
              k  <= '0;
            end
          end else if (!gx[0] && !gy[0]) begin
            gx <= gx >> 1;
            gy <= gy >> 1;
            k  <= k + 7'd1;
          end else begin
            state <= S_GODD;
          end
        end
        S_GODD: begin
          if (!gx[0]) gx <= gx >> 1;
          else state <= S_GLOOP;
        end
        S_GLOOP: begin
          if (gy == '0) begin
            gx    <= gx << k[5:0];
            qn    <= nm;
            qd    <= dn;
            rn    <= '0;
            rd    <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end else if (!gy[0]) begin
            gy <= gy >> 1;
          end else if (gx > gy) begin
            gx <= gy;
            gy <= gx - gy;
          end else begin
            gy <= gy - gx;
          end
        end
        S_DIV: begin
          rn    <= gen ? WIDE_W'(tn - {1'b0, gx}) : tn[WIDE_W-1:0];
          rd    <= ged ? WIDE_W'(td - {1'b0, gx}) : td[WIDE_W-1:0];
          qn    <= {qn[WIDE_W-2:0], gen};
          qd    <= {qd[WIDE_W-2:0], ged};
          cnt   <= cnt + 6'd1;
          if (cnt == 6'd63) state <= S_DONE;
        end
        S_DONE: begin
          // Hold the finished result until the output register is free.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            if (st != ST_OK) begin
              m_tdata <= '0;
              m_tuser <= st;
            end else if (ovf || res_ovf) begin
              m_tdata <= '0;
              m_tuser <= ST_OVERFLOW;
            end else begin
              m_tdata <= {1'b0, qd[WIDE_W-2:0], (neg ? (~qn + WIDE_W'(1)) : qn)};
              m_tuser <= ST_OK;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The divisor is never zero once the division runs.
  `ASSERT_IMPLIES(a_div_nonzero, state == S_DIV, gx != '0)
  // Inside the subtract loop the GCD operand gx is always odd.
  `ASSERT_IMPLIES(a_gcd_odd, state == S_GLOOP, gx[0])
  // An error result carries zero payload.
  `ASSERT_IMPLIES(a_err_zero, m_tvalid && m_tuser != ST_OK, m_tdata == '0)
  // A result is presented right after leaving the final state.
  `ASSERT_NEXT(a_done_out, state == S_DONE && (!m_tvalid || m_tready), m_tvalid)

endmodule
